/* design/json_token_scanner_assert.svh */
// assertion macros shared by the scanner modules
// expects clk_i and rst_ni in the module that uses them
`ifndef JSON_TOKEN_SCANNER_ASSERT_SVH
`define JSON_TOKEN_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
`define JTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define JTS_ASSERT(lbl, prop, msg)
`define JTS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* design/jts_pkg.sv */
// shared types, codes and helper functions of the json token scanner
// no dependencies
package jts_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [3:0] TK_LBRACE = 4'd0;
  localparam logic [3:0] TK_RBRACE = 4'd1;
  localparam logic [3:0] TK_COLON  = 4'd2;
  localparam logic [3:0] TK_LBRACK = 4'd3;
  localparam logic [3:0] TK_RBRACK = 4'd4;
  localparam logic [3:0] TK_COMMA  = 4'd5;
  localparam logic [3:0] TK_NULL   = 4'd6;
  localparam logic [3:0] TK_NUMBER = 4'd9;
  localparam logic [3:0] TK_STRING = 4'd10;

  localparam logic [2:0] ER_NONE       = 3'd0;
  localparam logic [2:0] ER_BAD_WORD   = 3'd1;
  localparam logic [2:0] ER_BAD_ESC    = 3'd2;
  localparam logic [2:0] ER_UNICODE    = 3'd3;
  localparam logic [2:0] ER_UNEXPECTED = 3'd4;
  localparam logic [2:0] ER_TRUNCATED  = 3'd5;

  localparam logic [1:0] WK_NULL  = 2'd0;
  localparam logic [1:0] WK_FALSE = 2'd1;
  localparam logic [1:0] WK_TRUE  = 2'd2;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_WORD = 6'b000010,
    MODE_NUM  = 6'b000100,
    MODE_STR  = 6'b001000,
    MODE_ESC  = 6'b010000,
    MODE_ERR  = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic       ch_valid;
    logic       last;
    logic [2:0] err;
  } jts_result_t;

  function automatic jts_result_t mk_res(logic [3:0] kind, logic [7:0] ch, logic ch_valid,
                                         logic last, logic [2:0] err);
    jts_result_t r;
    r.kind     = kind;
    r.ch       = ch;
    r.ch_valid = ch_valid;
    r.last     = last;
    r.err      = err;
    return r;
  endfunction

  // error beats carry the zero kind and no character
  function automatic jts_result_t err_res(logic [2:0] code);
    return mk_res(TK_LBRACE, 8'd0, 1'b0, 1'b0, code);
  endfunction

  function automatic logic is_num_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "." || c == "E" || c == "e" ||
           c == "+" || c == "-";
  endfunction

  function automatic logic [2:0] word_len(logic [1:0] k);
    return (k == WK_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] word_letter(logic [1:0] k, logic [2:0] idx);
    logic [7:0] c;
    c = 8'd0;
    case (k)
      WK_FALSE: begin
        case (idx)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'd0;
        endcase
      end
      WK_TRUE: begin
        case (idx)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'd0;
        endcase
      end
      default: begin
        case (idx)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'd0;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

/* design/json_token_scanner.sv */
// top level of the json token scanner: input register, lexer and result queue
// depends on jts_pkg, jts_lexer and jts_fifo
//
// One byte of JSON text is taken per beat and decoded in a single registered
// pass: each byte moves from the input register through the mode logic into a
// four-entry result queue, so a byte is accepted every cycle while the queue
// holds two or fewer beats. A byte that closes a number gives up to two result
// beats: the number close and any token of its own. The queue drains one beat
// per cycle while the downstream side is ready.
module json_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] char_out, [10:8] error_code, rest zero
  output logic [4:0]  m_axis_tuser_o,   // [3:0] token_kind, [4] char_valid
  output logic        m_axis_tlast_o    // token_last
);
  import jts_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        step;
  logic        room;
  logic [1:0]  emit;
  jts_result_t res0, res1, out_res;

  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  jts_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .emit_o (emit),
    .res0_o (res0),
    .res1_o (res1)
  );

  jts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step ? emit : 2'b00),
    .data0_i (res0),
    .data1_i (res1),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_res)
  );

  assign m_axis_tdata_o = {5'd0, out_res.err, out_res.ch};
  assign m_axis_tuser_o = {out_res.ch_valid, out_res.kind};
  assign m_axis_tlast_o = out_res.last;

endmodule

/* design/jts_lexer.sv */
// scan mode state and per-byte decode, up to two result beats per byte
// depends on jts_pkg and json_token_scanner_assert.svh
`include "json_token_scanner_assert.svh"
module jts_lexer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output logic [1:0]          emit_o,
  output jts_pkg::jts_result_t res0_o,
  output jts_pkg::jts_result_t res1_o
);
  import jts_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  wk_q, wk_d;
  logic [2:0]  li_q, li_d;

  logic        idle_emit;
  jts_result_t idle_res;
  mode_e       idle_mode;
  logic        idle_load;
  logic [1:0]  idle_wk;

  logic [1:0]  k;
  logic [2:0]  li_next;
  logic [7:0]  esc_ch;
  logic        esc_ok;

  // byte handled as between tokens
  always_comb begin
    idle_emit = 1'b0;
    idle_res  = '0;
    idle_mode = MODE_IDLE;
    idle_load = 1'b0;
    idle_wk   = WK_NULL;
    case (byte_i) inside
      8'h0d, 8'h0a, 8'h20, 8'h09: begin
      end
      "{": begin idle_emit = 1'b1; idle_res = mk_res(TK_LBRACE, 8'd0, 1'b0, 1'b1, ER_NONE); end
      "}": begin idle_emit = 1'b1; idle_res = mk_res(TK_RBRACE, 8'd0, 1'b0, 1'b1, ER_NONE); end
      ":": begin idle_emit = 1'b1; idle_res = mk_res(TK_COLON, 8'd0, 1'b0, 1'b1, ER_NONE); end
      "[": begin idle_emit = 1'b1; idle_res = mk_res(TK_LBRACK, 8'd0, 1'b0, 1'b1, ER_NONE); end
      "]": begin idle_emit = 1'b1; idle_res = mk_res(TK_RBRACK, 8'd0, 1'b0, 1'b1, ER_NONE); end
      ",": begin idle_emit = 1'b1; idle_res = mk_res(TK_COMMA, 8'd0, 1'b0, 1'b1, ER_NONE); end
      "n", "f", "t": begin
        if (last_i) begin
          idle_emit = 1'b1;
          idle_res  = err_res(ER_TRUNCATED);
        end else begin
          idle_load = 1'b1;
          idle_mode = MODE_WORD;
          idle_wk   = (byte_i == "n") ? WK_NULL : (byte_i == "f") ? WK_FALSE : WK_TRUE;
        end
      end
      "\"": begin
        if (last_i) begin
          idle_emit = 1'b1;
          idle_res  = err_res(ER_BAD_ESC);
        end else begin
          idle_mode = MODE_STR;
        end
      end
      default: begin
        idle_emit = 1'b1;
        if (is_num_char(byte_i)) begin
          idle_res  = mk_res(TK_NUMBER, byte_i, 1'b1, last_i, ER_NONE);
          idle_mode = last_i ? MODE_IDLE : MODE_NUM;
        end else begin
          idle_res  = err_res(ER_UNEXPECTED);
          idle_mode = last_i ? MODE_IDLE : MODE_ERR;
        end
      end
    endcase
  end

  assign k       = (wk_q == 2'd3) ? WK_NULL : wk_q;
  assign li_next = 3'(li_q + 3'd1);

  // escape letter decode
  always_comb begin
    esc_ok = 1'b1;
    esc_ch = 8'd0;
    case (byte_i)
      "\"": esc_ch = "\"";
      "\\": esc_ch = "\\";
      "/":  esc_ch = "/";
      "b":  esc_ch = 8'd8;
      "f":  esc_ch = 8'd12;
      "n":  esc_ch = 8'd10;
      "r":  esc_ch = 8'd13;
      "t":  esc_ch = 8'd9;
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    emit_o = 2'b00;
    res0_o = '0;
    res1_o = '0;
    mode_d = mode_q;
    wk_d   = wk_q;
    li_d   = li_q;
    unique case (mode_q)
      MODE_WORD: begin
        if (li_q >= word_len(k) || byte_i != word_letter(k, li_q)) begin
          emit_o = 2'b01;
          res0_o = err_res(ER_BAD_WORD);
          mode_d = last_i ? MODE_IDLE : MODE_ERR;
        end else if (li_next == word_len(k)) begin
          emit_o = 2'b01;
          res0_o = mk_res(4'(TK_NULL + {2'b00, k}), 8'd0, 1'b0, 1'b1, ER_NONE);
          mode_d = MODE_IDLE;
        end else if (last_i) begin
          emit_o = 2'b01;
          res0_o = err_res(ER_TRUNCATED);
          mode_d = MODE_IDLE;
        end else begin
          li_d = li_next;
        end
      end
      MODE_NUM: begin
        if (is_num_char(byte_i)) begin
          emit_o = 2'b01;
          res0_o = mk_res(TK_NUMBER, byte_i, 1'b1, last_i, ER_NONE);
          if (last_i) mode_d = MODE_IDLE;
        end else begin
          emit_o = {idle_emit, 1'b1};
          res0_o = mk_res(TK_NUMBER, 8'd0, 1'b0, 1'b1, ER_NONE);
          res1_o = idle_res;
          mode_d = idle_mode;
          if (idle_load) begin
            wk_d = idle_wk;
            li_d = 3'd1;
          end
        end
      end
      MODE_STR: begin
        if (byte_i == "\"") begin
          emit_o = 2'b01;
          res0_o = mk_res(TK_STRING, 8'd0, 1'b0, 1'b1, ER_NONE);
          mode_d = MODE_IDLE;
        end else if (last_i) begin
          emit_o = 2'b01;
          res0_o = err_res(ER_BAD_ESC);
          mode_d = MODE_IDLE;
        end else if (byte_i == "\\") begin
          mode_d = MODE_ESC;
        end else begin
          emit_o = 2'b01;
          res0_o = mk_res(TK_STRING, byte_i, 1'b1, 1'b0, ER_NONE);
        end
      end
      MODE_ESC: begin
        emit_o = 2'b01;
        if (byte_i == "u") begin
          res0_o = err_res(ER_UNICODE);
          mode_d = last_i ? MODE_IDLE : MODE_ERR;
        end else if (!esc_ok) begin
          res0_o = err_res(ER_BAD_ESC);
          mode_d = last_i ? MODE_IDLE : MODE_ERR;
        end else if (last_i) begin
          res0_o = err_res(ER_BAD_ESC);
          mode_d = MODE_IDLE;
        end else begin
          res0_o = mk_res(TK_STRING, esc_ch, 1'b1, 1'b0, ER_NONE);
          mode_d = MODE_STR;
        end
      end
      MODE_ERR: begin
        if (last_i) mode_d = MODE_IDLE;
      end
      default: begin
        emit_o = {1'b0, idle_emit};
        res0_o = idle_res;
        mode_d = idle_mode;
        if (idle_load) begin
          wk_d = idle_wk;
          li_d = 3'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      wk_q   <= WK_NULL;
      li_q   <= 3'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      wk_q   <= wk_d;
      li_q   <= li_d;
    end
  end

  // a second beat only ever follows a closed number
  `JTS_ASSERT(a_second_after_number, (step_i && emit_o[1]) |-> (emit_o[0] && res0_o.kind == TK_NUMBER && res0_o.last), "second beat without number close")
  `JTS_ASSERT(a_idle_after_last, (step_i && last_i) |=> (mode_q == MODE_IDLE), "not idle after last byte")

endmodule

/* design/jts_fifo.sv */
// result queue taking up to two beats per cycle and giving one when ready
// depends on jts_pkg and json_token_scanner_assert.svh
`include "json_token_scanner_assert.svh"
module jts_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_i,
  input  jts_pkg::jts_result_t data0_i,
  input  jts_pkg::jts_result_t data1_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output jts_pkg::jts_result_t data_o
);
  import jts_pkg::*;

  jts_result_t        entry_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr1;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic               pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign room_o  = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign wr_ptr1 = FIFO_AW'(wr_ptr_q + 1'b1);

  assign wr_ptr_d = FIFO_AW'(wr_ptr_q + FIFO_AW'(push_i[0]) + FIFO_AW'(push_i[1]));
  assign rd_ptr_d = FIFO_AW'(rd_ptr_q + FIFO_AW'(pop));
  assign count_d  = FIFO_CW'(count_q + FIFO_CW'(push_i[0]) + FIFO_CW'(push_i[1])
                    - FIFO_CW'(pop));

  always_ff @(posedge clk_i) begin
    if (push_i[0]) entry_q[wr_ptr_q] <= data0_i;
    if (push_i[1]) entry_q[wr_ptr1]  <= data1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `JTS_ASSERT_NEVER(a_count_bound, count_q > FIFO_CW'(FIFO_DEPTH), "queue count overflow")
  `JTS_ASSERT_NEVER(a_push_no_room, (push_i != 2'b00) && !room_o, "push without room")
  `JTS_ASSERT_NEVER(a_push_order, push_i[1] && !push_i[0], "second slot pushed alone")

endmodule
